// ===== design/servo_gait_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// servo gait sequencer assertion macros
// shared concurrent check forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SERVO_GAIT_SEQUENCER_UNIT_DEFINES_SVH
`define SERVO_GAIT_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define SGS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgs check failed");

// next-cycle implication
`define SGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgs check failed");

`endif

// ===== design/sgs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgs_pkg
// shared types, command and action codes, pose constants
// ----------------------------------------------------------------------------
package sgs_pkg;

	localparam int COUNTER_BITS = 16;
	localparam int THR_W        = 15;
	localparam int CMD_W        = 4;
	localparam int DIST_W       = 16;
	localparam int ANG_W        = 8;
	localparam int ACT_W        = 3;
	localparam int PHASE_W      = 6;

	localparam logic [CMD_W-1:0] CMD_NOP    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_FWD    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_BACK   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_LEFT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RIGHT  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SWAY   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_AUTO   = 4'd10;
	localparam logic [CMD_W-1:0] CMD_MANUAL = 4'd11;
	localparam logic [CMD_W-1:0] CMD_HOME   = 4'd12;

	localparam logic [ACT_W-1:0] ACT_IDLE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WALK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SWING = 3'd5;

	localparam logic [THR_W-1:0] THR_RESET = 15'd100;

	localparam logic [PHASE_W-1:0] PHASE_LAST = 6'd39;
	localparam logic [PHASE_W-1:0] PHASE_HALF = 6'd20;
	localparam logic [PHASE_W-1:0] PHASE_FULL = 6'd40;
	localparam logic [PHASE_W-1:0] STEP_LEN   = 6'd10;
	localparam logic [PHASE_W-1:0] STEP_TWO   = 6'd30;

	localparam logic [ANG_W-1:0] ANG_HIP_HI  = 8'd135;
	localparam logic [ANG_W-1:0] ANG_HIP_LO  = 8'd45;
	localparam logic [ANG_W-1:0] ANG_MAX     = 8'd180;
	localparam logic [ANG_W-1:0] ANG_ZERO    = 8'd0;
	localparam logic [ANG_W-1:0] ANG_STRIDE  = 8'd10;

	typedef enum logic [1:0] {
		POSE_NEUTRAL,
		POSE_WALK,
		POSE_SWING
	} pose_t;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic                     distance_valid;
		logic signed [DIST_W-1:0] distance_mm;
	} tick_t;

	typedef struct packed {
		logic               emit;
		pose_t              pose;
		logic [PHASE_W-1:0] phase;
	} step_t;

	typedef struct packed {
		logic [ANG_W-1:0] servo_a;
		logic [ANG_W-1:0] servo_b;
		logic [ANG_W-1:0] servo_c;
		logic [ANG_W-1:0] servo_d;
		logic [ANG_W-1:0] servo_e;
		logic [ANG_W-1:0] servo_f;
		logic [ANG_W-1:0] servo_g;
		logic [ANG_W-1:0] servo_h;
	} frame_t;

endpackage

// ===== design/sgs_ifs.sv =====
// ----------------------------------------------------------------------------
// sgs channel interfaces
// tick input, frame output and threshold write channels
// ----------------------------------------------------------------------------
interface sgs_tick_if;
	logic                                  valid;
	logic                                  ready;
	logic [sgs_pkg::CMD_W-1:0]             command;
	logic                                  distance_valid;
	logic signed [sgs_pkg::DIST_W-1:0]     distance_mm;

	modport source (output valid, command, distance_valid, distance_mm, input ready);
	modport sink (input valid, command, distance_valid, distance_mm, output ready);
endinterface

interface sgs_frame_if;
	logic                          valid;
	logic                          ready;
	logic [sgs_pkg::ANG_W-1:0]     servo_a;
	logic [sgs_pkg::ANG_W-1:0]     servo_b;
	logic [sgs_pkg::ANG_W-1:0]     servo_c;
	logic [sgs_pkg::ANG_W-1:0]     servo_d;
	logic [sgs_pkg::ANG_W-1:0]     servo_e;
	logic [sgs_pkg::ANG_W-1:0]     servo_f;
	logic [sgs_pkg::ANG_W-1:0]     servo_g;
	logic [sgs_pkg::ANG_W-1:0]     servo_h;

	modport source (output valid, servo_a, servo_b, servo_c, servo_d,
		servo_e, servo_f, servo_g, servo_h, input ready);
	modport sink (input valid, servo_a, servo_b, servo_c, servo_d,
		servo_e, servo_f, servo_g, servo_h, output ready);
endinterface

interface sgs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sgs_pkg::THR_W-1:0]     obstacle_threshold_mm;

	modport source (output valid, obstacle_threshold_mm, input ready);
	modport sink (input valid, obstacle_threshold_mm, output ready);
endinterface

// ===== design/servo_gait_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// servo_gait_sequencer_unit
// tick-driven gait sequencer for an eight-servo walker
//
// channel  dir  word
// tick     in   command, distance_valid, distance_mm
// frame    out  servo_a .. servo_h
// cfg      in   obstacle_threshold_mm
//
// one tick per cycle sustained while frame is not stalled; a frame is presented only for ticks that emit one
// input register, state and pose logic, output register
// a stalled frame holds the tick stage; one tick still enters behind it
// arst_n clears action, mode, counter and threshold (100 mm), no clearing pass
// ----------------------------------------------------------------------------
module servo_gait_sequencer_unit (
	input  logic         clk,
	input  logic         arst_n,
	sgs_tick_if.sink     tick,
	sgs_frame_if.source  frame,
	sgs_cfg_if.sink      cfg
);
	import sgs_pkg::*;

	tick_t            tick_s1;
	logic             valid_s1;
	logic             adv;
	logic [THR_W-1:0] thr_q;
	step_t            step;
	frame_t           pose_frame;
	frame_t           frame_q;
	logic             out_valid_q;

	assign adv        = valid_s1 && (!out_valid_q || frame.ready);
	assign tick.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.obstacle_threshold_mm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.command        <= tick.command;
			tick_s1.distance_valid <= tick.distance_valid;
			tick_s1.distance_mm    <= tick.distance_mm;
		end
	end

	sgs_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (tick_s1),
		.thr    (thr_q),
		.step   (step)
	);

	sgs_pose u_pose (
		.step  (step),
		.frame (pose_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step.emit;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step.emit) begin
			frame_q <= pose_frame;
		end
	end

	assign frame.valid   = out_valid_q;
	assign frame.servo_a = frame_q.servo_a;
	assign frame.servo_b = frame_q.servo_b;
	assign frame.servo_c = frame_q.servo_c;
	assign frame.servo_d = frame_q.servo_d;
	assign frame.servo_e = frame_q.servo_e;
	assign frame.servo_f = frame_q.servo_f;
	assign frame.servo_g = frame_q.servo_g;
	assign frame.servo_h = frame_q.servo_h;
endmodule

// ===== design/sgs_state.sv =====
// ----------------------------------------------------------------------------
// sgs_state
// action, mode and tick counter update; picks the pose for each tick
// ----------------------------------------------------------------------------
`include "servo_gait_sequencer_unit_defines.svh"

module sgs_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  sgs_pkg::tick_t              item,
	input  logic [sgs_pkg::THR_W-1:0]   thr,
	output sgs_pkg::step_t              step
);
	import sgs_pkg::*;

	logic [COUNTER_BITS-1:0] tick_q, tick_n;
	logic [PHASE_W-1:0]      phase_q, phase_n;
	logic [ACT_W-1:0]        action_q, action_n;
	logic                    auto_q, auto_n;
	logic                    neutral;
	logic signed [DIST_W-1:0] thr_s;

	assign thr_s = signed'({1'b0, thr});

	always_comb begin
		if (tick_q == {COUNTER_BITS{1'b1}}) begin
			tick_n  = '0;
			phase_n = '0;
		end else begin
			tick_n  = tick_q + 1'b1;
			phase_n = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
		end
		action_n = action_q;
		auto_n   = auto_q;
		neutral  = 1'b0;
		case (item.command)
			CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_SWAY: begin
				action_n = ACT_W'(item.command);
				tick_n   = '0;
				phase_n  = '0;
				auto_n   = 1'b0;
			end
			CMD_AUTO: begin
				auto_n   = 1'b1;
				action_n = ACT_WALK;
				tick_n   = '0;
				phase_n  = '0;
			end
			CMD_MANUAL: begin
				auto_n = 1'b0;
			end
			CMD_HOME: begin
				auto_n   = 1'b0;
				action_n = ACT_IDLE;
				neutral  = 1'b1;
			end
			default: begin
			end
		endcase
		if (item.distance_valid && auto_n) begin
			if (item.distance_mm > 0 && item.distance_mm < thr_s) begin
				action_n = ACT_LEFT;
			end else if (item.distance_mm >= thr_s) begin
				action_n = ACT_WALK;
			end
		end
		step.emit  = neutral || action_n == ACT_WALK || action_n == ACT_SWING;
		step.pose  = neutral ? POSE_NEUTRAL : (action_n == ACT_WALK ? POSE_WALK : POSE_SWING);
		step.phase = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			phase_q  <= '0;
			action_q <= ACT_IDLE;
			auto_q   <= 1'b0;
		end else if (adv) begin
			tick_q   <= tick_n;
			phase_q  <= phase_n;
			action_q <= action_n;
			auto_q   <= auto_n;
		end
	end

	// phase is the counter mod 40
	`SGS_ASSERT_NOW(a_phase_range, 1'b1, phase_q <= PHASE_LAST)
	`SGS_ASSERT_NOW(a_phase_zero, tick_q == '0, phase_q == '0)
	// auto mode only ever walks or turns away
	`SGS_ASSERT_NOW(a_auto_action, auto_q, action_q == ACT_WALK || action_q == ACT_LEFT)
	`SGS_ASSERT_NEXT(a_reset_cmd, adv && item.command == CMD_HOME,
		action_q == ACT_IDLE && !auto_q)
endmodule

// ===== design/sgs_pose.sv =====
// ----------------------------------------------------------------------------
// sgs_pose
// eight-angle frame for neutral, walking and swing poses
// ----------------------------------------------------------------------------
module sgs_pose (
	input  sgs_pkg::step_t  step,
	output sgs_pkg::frame_t frame
);
	import sgs_pkg::*;

	logic             first;
	logic [ANG_W-1:0] e;

	assign first = step.phase < STEP_LEN ||
		(step.phase >= PHASE_HALF && step.phase < STEP_TWO);
	assign e = (step.phase < PHASE_HALF) ? ANG_W'({step.phase, 1'b0})
		: ANG_W'({PHASE_FULL - step.phase, 1'b0});

	always_comb begin
		frame.servo_a = ANG_HIP_HI;
		frame.servo_b = ANG_HIP_LO;
		frame.servo_c = ANG_HIP_LO;
		frame.servo_d = ANG_HIP_HI;
		frame.servo_e = ANG_ZERO;
		frame.servo_f = ANG_MAX;
		frame.servo_g = ANG_ZERO;
		frame.servo_h = ANG_MAX;
		case (step.pose)
			POSE_WALK: begin
				frame.servo_a = first ? ANG_HIP_HI + ANG_STRIDE : ANG_HIP_HI - ANG_STRIDE;
				frame.servo_b = first ? ANG_HIP_LO - ANG_STRIDE : ANG_HIP_LO + ANG_STRIDE;
				frame.servo_c = first ? ANG_HIP_LO - ANG_STRIDE : ANG_HIP_LO + ANG_STRIDE;
				frame.servo_d = first ? ANG_HIP_HI + ANG_STRIDE : ANG_HIP_HI - ANG_STRIDE;
			end
			POSE_SWING: begin
				frame.servo_e = e;
				frame.servo_f = ANG_MAX - e;
				frame.servo_g = e;
				frame.servo_h = ANG_MAX - e;
			end
			default: begin
			end
		endcase
	end
endmodule
